// ----- sv/bas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

	// set geometry
	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;

	// fixed port widths
	localparam int OPCODE_BITS = 3;
	localparam int KEY_IN_BITS = 32;
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 7;

	// stored key width: the key port carries at most KEY_IN_BITS bits
	localparam int KEY_W = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_ADD      = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_CONTAINS = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_LIST     = 3'd4
	} opcode_t;

	// one result as produced by the sequencer
	typedef struct packed {
		logic             vld;
		logic             ok;
		logic [KEY_W-1:0] value;
		logic             last;
		logic [CNT_W-1:0] cnt;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/bas_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/bas_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bas_seq (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [bas_pkg::OPCODE_BITS-1:0]      opcode,
	input  wire logic [bas_pkg::KEY_IN_BITS-1:0]      key,
	output logic                                      busy,
	output bas_pkg::res_t                             res
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_RDLAST = 4'b0100,
		ST_MOVE   = 4'b1000
	} state_t;

	state_t                          state_q, state_d;
	bas_pkg::opcode_t                op_q, op_d;
	logic [bas_pkg::KEY_W-1:0]       key_q, key_d;
	logic [bas_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic [bas_pkg::IDX_W-1:0]       rd_idx_q, rd_idx_d;
	logic [bas_pkg::IDX_W-1:0]       pidx_q, pidx_d;
	logic [bas_pkg::IDX_W-1:0]       fidx_q, fidx_d;
	logic                            iss_q, iss_d;
	logic                            pv_q, pv_d;

	logic                            ram_we;
	logic [bas_pkg::IDX_W-1:0]       ram_waddr;
	logic [bas_pkg::KEY_W-1:0]       ram_wdata;
	logic [bas_pkg::IDX_W-1:0]       ram_raddr;
	logic [bas_pkg::KEY_W-1:0]       ram_rdata;

	logic [bas_pkg::IDX_W-1:0]       last_idx;
	logic                            hit;
	logic                            at_end;

	bas_ram #(
		.WIDTH(bas_pkg::KEY_W),
		.DEPTH(bas_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign last_idx = bas_pkg::IDX_W'(cnt_q - bas_pkg::CNT_W'(1));
	// the one shared comparator
	assign hit      = (ram_rdata == key_q);
	assign at_end   = (pidx_q == last_idx);
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		rd_idx_d  = rd_idx_q;
		pidx_d    = pidx_q;
		fidx_d    = fidx_q;
		iss_d     = iss_q;
		pv_d      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = key_q;
		ram_raddr = rd_idx_q;
		res.vld   = 1'b0;
		res.ok    = 1'b0;
		res.value = '0;
		res.last  = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d     = bas_pkg::opcode_t'(opcode);
					key_d    = key[bas_pkg::KEY_W-1:0];
					rd_idx_d = '0;
					case (bas_pkg::opcode_t'(opcode)) inside
						bas_pkg::OP_CLEAR: begin
							cnt_d   = '0;
							res.vld = 1'b1;
							res.ok  = 1'b1;
						end
						bas_pkg::OP_ADD: begin
							if (cnt_q == bas_pkg::CNT_W'(bas_pkg::CAPACITY)) begin
								res.vld = 1'b1;
							end else if (cnt_q == '0) begin
								// empty set: nothing to search, write straight in
								ram_we    = 1'b1;
								ram_waddr = '0;
								ram_wdata = key[bas_pkg::KEY_W-1:0];
								cnt_d     = bas_pkg::CNT_W'(1);
								res.vld   = 1'b1;
								res.ok    = 1'b1;
							end else begin
								state_d = ST_SCAN;
							end
						end
						bas_pkg::OP_REMOVE, bas_pkg::OP_CONTAINS, bas_pkg::OP_LIST: begin
							if (cnt_q == '0) begin
								res.vld = 1'b1;
							end else begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							res.vld = 1'b1;
						end
					endcase
					// reads are issued only when a scan follows
					iss_d = (state_d == ST_SCAN);
				end
			end

			ST_SCAN: begin
				// issue side: one read per cycle up to the last entry
				if (iss_q) begin
					pidx_d = rd_idx_q;
					pv_d   = 1'b1;
					if (rd_idx_q == last_idx) begin
						iss_d = 1'b0;
					end else begin
						rd_idx_d = rd_idx_q + bas_pkg::IDX_W'(1);
					end
				end
				// compare side: data of the previous read
				if (pv_q) begin
					case (op_q)
						bas_pkg::OP_LIST: begin
							res.vld   = 1'b1;
							res.ok    = 1'b1;
							res.value = ram_rdata;
							res.last  = at_end;
							if (at_end) begin
								state_d = ST_IDLE;
							end
						end
						bas_pkg::OP_CONTAINS: begin
							if (hit || at_end) begin
								res.vld = 1'b1;
								res.ok  = hit;
								state_d = ST_IDLE;
							end
						end
						bas_pkg::OP_ADD: begin
							if (hit) begin
								res.vld = 1'b1;
								state_d = ST_IDLE;
							end else if (at_end) begin
								ram_we    = 1'b1;
								ram_waddr = cnt_q[bas_pkg::IDX_W-1:0];
								ram_wdata = key_q;
								cnt_d     = cnt_q + bas_pkg::CNT_W'(1);
								res.vld   = 1'b1;
								res.ok    = 1'b1;
								state_d   = ST_IDLE;
							end
						end
						bas_pkg::OP_REMOVE: begin
							if (hit && at_end) begin
								cnt_d   = cnt_q - bas_pkg::CNT_W'(1);
								res.vld = 1'b1;
								res.ok  = 1'b1;
								state_d = ST_IDLE;
							end else if (hit) begin
								fidx_d  = pidx_q;
								state_d = ST_RDLAST;
							end else if (at_end) begin
								res.vld = 1'b1;
								state_d = ST_IDLE;
							end
						end
						default: begin
							res.vld = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
				if (state_d != ST_SCAN) begin
					pv_d  = 1'b0;
					iss_d = 1'b0;
				end
			end

			ST_RDLAST: begin
				ram_raddr = last_idx;
				state_d   = ST_MOVE;
			end

			ST_MOVE: begin
				// last entry fills the hole
				ram_we    = 1'b1;
				ram_waddr = fidx_q;
				ram_wdata = ram_rdata;
				cnt_d     = cnt_q - bas_pkg::CNT_W'(1);
				res.vld   = 1'b1;
				res.ok    = 1'b1;
				state_d   = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.cnt = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iss_q   <= 1'b0;
			pv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			iss_q   <= iss_d;
			pv_q    <= pv_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		key_q    <= key_d;
		rd_idx_q <= rd_idx_d;
		pidx_q   <= pidx_d;
		fidx_q   <= fidx_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bas_pkg::CNT_W'(bas_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && res.last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final result");

	a_idle_no_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pv_q && !iss_q))
		else $error("scan pipeline active while idle");

	a_pipe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pv_q) |-> (pidx_q <= last_idx))
		else $error("compare beyond last entry");

endmodule

`default_nettype wire

// ----- sv/bounded_array_set_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// set of up to bas_pkg::CAPACITY distinct keys kept unordered in a store with
// one write port and one read port, searched linearly by one comparator. a
// request transfers on a clock edge with start high and busy low; results come
// out one per cycle marked by done, in the cycle after the sequencer forms them,
// and the receiver cannot stall them. clear, unused opcodes, a full-set add, and
// any search or list on an empty set finish at the accepting edge. add, remove
// and contains read one entry per cycle through the store's registered read
// port and stop early on a hit; a remove that hits before the last entry then
// reads the last entry and moves it into the hole. list gives one result per
// cycle once the first read returns. busy drops in the cycle the final result
// is driven, so the next request may transfer while that result is still on
// the outputs.
module bounded_array_set_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [bas_pkg::OPCODE_BITS-1:0]      opcode,
	input  wire logic [bas_pkg::KEY_IN_BITS-1:0]      key,
	output logic                                      done,
	output logic                                      ok,
	output logic      [bas_pkg::VALUE_BITS-1:0]       entry_value,
	output logic                                      last,
	output logic      [bas_pkg::COUNT_BITS-1:0]       count,
	output logic                                      empty_res
);

	bas_pkg::res_t                    res;

	// output register: each result shows for exactly one cycle
	logic                             done_q;
	logic                             ok_q;
	logic [bas_pkg::VALUE_BITS-1:0]   value_q;
	logic                             last_q;
	logic [bas_pkg::COUNT_BITS-1:0]   count_q;
	logic                             empty_q;

	// sequencer, store and comparator
	bas_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(opcode),
		.key   (key),
		.busy  (busy),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.vld;
		end
	end

	// payload needs no reset; it only counts under done
	always_ff @(posedge clk) begin
		ok_q    <= res.ok;
		value_q <= bas_pkg::VALUE_BITS'(res.value);
		last_q  <= res.last;
		count_q <= bas_pkg::COUNT_BITS'(res.cnt);
		empty_q <= (res.cnt == '0);
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign entry_value = value_q;
	assign last        = last_q;
	assign count       = count_q;
	assign empty_res   = empty_q;

endmodule

`default_nettype wire
